// ===== hdl/assert_macros.svh =====
// Assertion macros used by the port-level checker of this block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define CHK_HOLDS(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("checker assertion failed");

// A condition in one cycle that forces another in the next cycle.
`define CHK_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("checker assertion failed");

`endif

// ===== hdl/tsamm_pkg.sv =====
// Package with the types, codes and constants of the time-slot averager.
package tsamm_pkg;

    localparam int TEMP_W = 16;
    localparam int CNT_W  = 16;
    localparam int SLOT_W = 11;

    localparam int DEF_NUM_SLOTS    = 96;
    localparam int DEF_MIN_PER_SLOT = 15;
    localparam int MIN_PER_HOUR     = 60;

    localparam logic [SLOT_W-1:0]        NO_SLOT   = 11'd2047;
    localparam logic signed [TEMP_W-1:0] MIN_RESET = 16'sd12800;
    localparam logic signed [TEMP_W-1:0] MAX_RESET = 16'sd0;
    localparam logic [CNT_W-1:0]         CNT_MAX   = 16'hFFFF;

    // Serial divider geometry: dividend, divisor and iteration counter widths.
    localparam int DIV_DW = 32;
    localparam int DIV_VW = 17;
    localparam int DIV_CW = 6;

    localparam logic [1:0] REQ_SAMPLE   = 2'd0;
    localparam logic [1:0] REQ_RESET_MM = 2'd1;
    localparam logic [1:0] REQ_CLEAR    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUTE,
        ST_PICK,
        ST_SUM,
        ST_MEAN_WAIT,
        ST_PUBLISH
    } tsamm_state_t;

    typedef struct packed {
        logic load_in;
        logic slot_take;
        logic open_slot;
        logic mul_go;
        logic div_go_mean;
        logic mean_take;
        logic misc_apply;
        logic publish;
    } tsamm_cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       div_done;
        logic       same_slot;
    } tsamm_stat_t;

endpackage

// ===== hdl/tsamm_div.sv =====
// Restoring serial divider, one quotient bit per cycle.
module tsamm_div
    import tsamm_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_DW-1:0] dividend,
    input  logic [DIV_VW-1:0] divisor,
    input  logic [DIV_CW-1:0] len,
    output logic [DIV_DW-1:0] quotient,
    output logic              done
);

    logic [DIV_DW-1:0] num_reg;
    logic [DIV_VW-1:0] den_reg;
    logic [DIV_VW-1:0] rem_reg;
    logic [DIV_DW-1:0] quo_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIV_VW:0]   rem_shift;
    logic              fits;
    logic [DIV_VW:0]   rem_trial;

    always_comb
    begin
        rem_shift = {rem_reg, num_reg[DIV_DW-1]};
        fits      = rem_shift >= {1'b0, den_reg};
        rem_trial = fits ? (rem_shift - {1'b0, den_reg}) : rem_shift;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            cnt_reg  <= len;
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == DIV_CW'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            num_reg <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= '0;
        end
        else if (busy_reg)
        begin
            num_reg <= {num_reg[DIV_DW-2:0], 1'b0};
            rem_reg <= rem_trial[DIV_VW-1:0];
            quo_reg <= {quo_reg[DIV_DW-2:0], fits};
        end
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

// ===== hdl/tsamm_dp.sv =====
// Datapath: input capture, slot state, mean update and output register.
module tsamm_dp
    import tsamm_pkg::*;
#(
    parameter int NUM_SLOTS        = DEF_NUM_SLOTS,
    parameter int MINUTES_PER_SLOT = DEF_MIN_PER_SLOT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  tsamm_cmd_t               cmd,
    output tsamm_stat_t              stat,
    input  logic [1:0]               req_type,
    input  logic signed [TEMP_W-1:0] temperature,
    input  logic [4:0]               hour,
    input  logic [5:0]               minute,
    output logic signed [TEMP_W-1:0] now_temp,
    output logic signed [TEMP_W-1:0] min_seen,
    output logic signed [TEMP_W-1:0] max_seen,
    output logic [SLOT_W-1:0]        slot_number,
    output logic signed [TEMP_W-1:0] slot_mean,
    output logic [CNT_W-1:0]         slot_samples,
    output logic                     slot_started
);

    localparam int PROD_W = TEMP_W + CNT_W + 2;

    // The slot index is minutes / MINUTES_PER_SLOT, taken as a multiply by a
    // rounded-up reciprocal; it is exact for every minute count below 2^SLOT_W.
    localparam int SLOT_SH = SLOT_W + $clog2(MINUTES_PER_SLOT);
    localparam int RECIP_W = SLOT_W + 1;
    localparam int SPROD_W = SLOT_W + RECIP_W;
    localparam logic [RECIP_W-1:0] SLOT_RECIP =
        RECIP_W'(((longint'(1) << SLOT_SH) + longint'(MINUTES_PER_SLOT) - 1)
                 / longint'(MINUTES_PER_SLOT));

    // Captured request.
    logic [1:0]               req_reg;
    logic signed [TEMP_W-1:0] x_reg;
    logic [4:0]               hour_reg;
    logic [5:0]               minute_reg;

    // Working registers.
    logic [SLOT_W-1:0]        slot_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic                     neg_reg;

    // Architectural state.
    logic signed [TEMP_W-1:0] latest_reg;
    logic signed [TEMP_W-1:0] min_reg;
    logic signed [TEMP_W-1:0] max_reg;
    logic [SLOT_W-1:0]        active_reg;
    logic signed [TEMP_W-1:0] mean_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     started_reg;

    // Output register.
    logic signed [TEMP_W-1:0] o_now_reg;
    logic signed [TEMP_W-1:0] o_min_reg;
    logic signed [TEMP_W-1:0] o_max_reg;
    logic [SLOT_W-1:0]        o_slot_reg;
    logic signed [TEMP_W-1:0] o_mean_reg;
    logic [CNT_W-1:0]         o_cnt_reg;
    logic                     o_started_reg;

    logic [SLOT_W-1:0]        minutes;
    logic [SPROD_W-1:0]       slot_prod;
    logic [SLOT_W-1:0]        slot_q;
    logic [SLOT_W-1:0]        slot_sat;
    logic signed [CNT_W+1:0]  cnt_s;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] sum;
    logic [PROD_W-1:0]        sum_mag;
    logic                     div_start;
    logic [DIV_DW-1:0]        div_dividend;
    logic [DIV_VW-1:0]        div_divisor;
    logic [DIV_CW-1:0]        div_len;
    logic [DIV_DW-1:0]        div_quo;
    logic                     div_done;
    logic [TEMP_W-1:0]        q_mag;
    logic signed [TEMP_W-1:0] avg;
    logic signed [TEMP_W-1:0] min_upd;
    logic signed [TEMP_W-1:0] max_upd;

    always_comb
    begin
        minutes   = hour_reg * SLOT_W'(MIN_PER_HOUR) + SLOT_W'(minute_reg);
        slot_prod = SPROD_W'(minutes) * SPROD_W'(SLOT_RECIP);
        slot_q    = SLOT_W'(slot_prod >> SLOT_SH);
        slot_sat  = (slot_q >= SLOT_W'(NUM_SLOTS)) ? SLOT_W'(NUM_SLOTS - 1) : slot_q;

        cnt_s     = $signed({2'b00, count_reg});
        prod_next = mean_reg * cnt_s;

        sum     = prod_reg + PROD_W'(x_reg);
        sum_mag = sum[PROD_W-1] ? PROD_W'(-sum) : PROD_W'(sum);

        div_start    = cmd.div_go_mean;
        div_dividend = sum_mag[DIV_DW-1:0];
        div_divisor  = {1'b0, count_reg} + 1'b1;
        div_len      = DIV_CW'(DIV_DW);

        q_mag = div_quo[TEMP_W-1:0];
        avg   = neg_reg ? $signed(-q_mag) : $signed(q_mag);

        min_upd = (x_reg < min_reg) ? x_reg : min_reg;
        max_upd = (x_reg > max_reg) ? x_reg : max_reg;
    end

    tsamm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .len      (div_len),
        .quotient (div_quo),
        .done     (div_done)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            req_reg    <= req_type;
            x_reg      <= temperature;
            hour_reg   <= hour;
            minute_reg <= minute;
        end
        if (cmd.slot_take)
            slot_reg <= slot_sat;
        if (cmd.mul_go)
            prod_reg <= prod_next;
        if (cmd.div_go_mean)
            neg_reg <= sum[PROD_W-1];
        if (cmd.publish)
        begin
            o_now_reg     <= latest_reg;
            o_min_reg     <= min_reg;
            o_max_reg     <= max_reg;
            o_slot_reg    <= active_reg;
            o_mean_reg    <= mean_reg;
            o_cnt_reg     <= count_reg;
            o_started_reg <= started_reg;
        end
    end

    // Only the active slot is ever read back, so its mean and count live in
    // registers; every other slot is overwritten before it becomes active.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latest_reg  <= '0;
            min_reg     <= MIN_RESET;
            max_reg     <= MAX_RESET;
            active_reg  <= NO_SLOT;
            mean_reg    <= '0;
            count_reg   <= '0;
            started_reg <= 1'b0;
        end
        else if (cmd.open_slot)
        begin
            latest_reg  <= x_reg;
            min_reg     <= min_upd;
            max_reg     <= max_upd;
            active_reg  <= slot_reg;
            mean_reg    <= x_reg;
            count_reg   <= CNT_W'(1);
            started_reg <= 1'b1;
        end
        else if (cmd.mean_take)
        begin
            latest_reg  <= x_reg;
            min_reg     <= min_upd;
            max_reg     <= max_upd;
            mean_reg    <= avg;
            count_reg   <= (count_reg == CNT_MAX) ? count_reg : count_reg + 1'b1;
            started_reg <= 1'b0;
        end
        else if (cmd.misc_apply)
        begin
            started_reg <= 1'b0;
            case (req_reg)
                REQ_RESET_MM:
                begin
                    min_reg <= MIN_RESET;
                    max_reg <= MAX_RESET;
                end
                REQ_CLEAR:
                begin
                    min_reg   <= MIN_RESET;
                    max_reg   <= MAX_RESET;
                    mean_reg  <= '0;
                    count_reg <= '0;
                end
                default:
                begin
                end
            endcase
        end
    end

    assign stat.req       = req_reg;
    assign stat.div_done  = div_done;
    assign stat.same_slot = (slot_reg == active_reg);

    assign now_temp     = o_now_reg;
    assign min_seen     = o_min_reg;
    assign max_seen     = o_max_reg;
    assign slot_number  = o_slot_reg;
    assign slot_mean    = o_mean_reg;
    assign slot_samples = o_cnt_reg;
    assign slot_started = o_started_reg;

endmodule

// ===== hdl/tsamm_ctrl.sv =====
// Controller state machine that sequences one request through the datapath.
module tsamm_ctrl
    import tsamm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    output logic        out_valid,
    input  logic        out_stall,
    input  tsamm_stat_t stat,
    output tsamm_cmd_t  cmd
);

    tsamm_state_t state_reg;
    tsamm_state_t state_next;
    logic         out_valid_reg;
    logic         out_valid_next;
    logic         out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_comb
    begin
        cmd            = '0;
        state_next     = state_reg;
        out_free       = !out_valid_reg || !out_stall;
        out_valid_next = out_valid_reg && out_stall;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load_in = 1'b1;
                    state_next  = ST_ROUTE;
                end
            end
            ST_ROUTE:
            begin
                if (stat.req == REQ_SAMPLE)
                begin
                    cmd.slot_take = 1'b1;
                    state_next    = ST_PICK;
                end
                else
                begin
                    cmd.misc_apply = 1'b1;
                    state_next     = ST_PUBLISH;
                end
            end
            ST_PICK:
            begin
                if (stat.same_slot)
                begin
                    cmd.mul_go = 1'b1;
                    state_next = ST_SUM;
                end
                else
                begin
                    cmd.open_slot = 1'b1;
                    state_next    = ST_PUBLISH;
                end
            end
            ST_SUM:
            begin
                cmd.div_go_mean = 1'b1;
                state_next      = ST_MEAN_WAIT;
            end
            ST_MEAN_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.mean_take = 1'b1;
                    state_next    = ST_PUBLISH;
                end
            end
            ST_PUBLISH:
            begin
                if (out_free)
                begin
                    cmd.publish    = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;

endmodule

// ===== hdl/time_slot_average_min_max.sv =====
// Top level of the time-slot temperature averager with running min and max.
//
// One request is taken on the input channel when in_valid is high and in_stall
// is low. A request is a sample (temperature in signed Q8.8 with hour and
// minute), a reset of the running minimum and maximum, or a clear of all slot
// statistics together with the minimum and maximum. Every request produces
// exactly one result transfer on the output channel, reporting the latest
// temperature, the running extremes, the active slot and its mean and count.
//
// The block works on one request at a time. The slot index comes from a
// combinational reciprocal multiply. A sample opening a new slot passes the
// route, pick and publish states; a sample in the active slot also passes
// sum and mean-wait, where the serial divider forms the running mean; other
// requests go from route to publish. out_valid rises once publish finds the
// output register free; the next request is taken back in the idle state.
//
// The result sits in an output register: a new request is taken while it
// waits, and a finished result waits only if the previous one is still
// stalled. While out_stall is high the result holds steady. Reset returns the
// extremes to 50.0 C and 0.0 C, the slot to "none yet" (2047) and the mean and
// count to zero, and leaves no result pending.
module time_slot_average_min_max
    import tsamm_pkg::*;
#(
    parameter int NUM_SLOTS        = DEF_NUM_SLOTS,
    parameter int MINUTES_PER_SLOT = DEF_MIN_PER_SLOT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               req_type,
    input  logic signed [TEMP_W-1:0] temperature,
    input  logic [4:0]               hour,
    input  logic [5:0]               minute,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic signed [TEMP_W-1:0] now_temp,
    output logic signed [TEMP_W-1:0] min_seen,
    output logic signed [TEMP_W-1:0] max_seen,
    output logic [SLOT_W-1:0]        slot_number,
    output logic signed [TEMP_W-1:0] slot_mean,
    output logic [CNT_W-1:0]         slot_samples,
    output logic                     slot_started
);

    // Commands flow from the controller to the datapath, status flows back.
    tsamm_cmd_t  cmd;
    tsamm_stat_t stat;

    tsamm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .stat      (stat),
        .cmd       (cmd)
    );

    // The datapath holds the captured request, the slot state, the multiplier
    // and serial divider for the running mean, and the output register.
    tsamm_dp #(
        .NUM_SLOTS        (NUM_SLOTS),
        .MINUTES_PER_SLOT (MINUTES_PER_SLOT)
    ) u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .stat         (stat),
        .req_type     (req_type),
        .temperature  (temperature),
        .hour         (hour),
        .minute       (minute),
        .now_temp     (now_temp),
        .min_seen     (min_seen),
        .max_seen     (max_seen),
        .slot_number  (slot_number),
        .slot_mean    (slot_mean),
        .slot_samples (slot_samples),
        .slot_started (slot_started)
    );

endmodule

// ===== hdl/tsamm_checker.sv =====
// Port-level checker for the time-slot averager and its bind to the top level.
`include "assert_macros.svh"

module tsamm_checker
    import tsamm_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     in_valid,
    input logic                     in_stall,
    input logic [1:0]               req_type,
    input logic signed [TEMP_W-1:0] temperature,
    input logic [4:0]               hour,
    input logic [5:0]               minute,
    input logic                     out_valid,
    input logic                     out_stall,
    input logic signed [TEMP_W-1:0] now_temp,
    input logic signed [TEMP_W-1:0] min_seen,
    input logic signed [TEMP_W-1:0] max_seen,
    input logic [SLOT_W-1:0]        slot_number,
    input logic signed [TEMP_W-1:0] slot_mean,
    input logic [CNT_W-1:0]         slot_samples,
    input logic                     slot_started
);

    // A stalled result stays offered.
    `CHK_NEXT(a_out_hold, out_valid && out_stall, out_valid)

    // A stalled result keeps its payload.
    `CHK_NEXT(a_out_stable, out_valid && out_stall, $stable(now_temp) && $stable(min_seen) && $stable(max_seen) && $stable(slot_number) && $stable(slot_mean) && $stable(slot_samples) && $stable(slot_started))

    // A freshly opened slot holds just the sample that opened it.
    `CHK_HOLDS(a_open_slot, !(out_valid && slot_started) || (slot_samples == 16'd1 && slot_mean == now_temp))

    // With no slot yet, the slot statistics read as zero.
    `CHK_HOLDS(a_no_slot, !(out_valid && slot_number == NO_SLOT) || (slot_samples == 16'd0 && slot_mean == 16'sd0 && !slot_started))

    // A taken request keeps the block busy in the following cycle.
    `CHK_NEXT(a_busy_after_take, in_valid && !in_stall, in_stall)

endmodule

bind time_slot_average_min_max tsamm_checker u_tsamm_checker (.*);

// ===== verif/tsamm_checker.sv =====
// Checker that tracks the slot statistics and compares every result transfer.
module tsamm_scoreboard
    import tsamm_pkg::*;
#(
    parameter int NUM_SLOTS        = DEF_NUM_SLOTS,
    parameter int MINUTES_PER_SLOT = DEF_MIN_PER_SLOT
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [1:0]               req_type,
    input  logic signed [TEMP_W-1:0] temperature,
    input  logic [4:0]               hour,
    input  logic [5:0]               minute,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic signed [TEMP_W-1:0] now_temp,
    input  logic signed [TEMP_W-1:0] min_seen,
    input  logic signed [TEMP_W-1:0] max_seen,
    input  logic [SLOT_W-1:0]        slot_number,
    input  logic signed [TEMP_W-1:0] slot_mean,
    input  logic [CNT_W-1:0]         slot_samples,
    input  logic                     slot_started,
    output int                       fail_count,
    output int                       pending,
    output int                       checked
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SHOW_LIMIT = 10;

    typedef struct packed {
        logic signed [TEMP_W-1:0] now_temp;
        logic signed [TEMP_W-1:0] min_seen;
        logic signed [TEMP_W-1:0] max_seen;
        logic [SLOT_W-1:0]        slot_number;
        logic signed [TEMP_W-1:0] slot_mean;
        logic [CNT_W-1:0]         slot_samples;
        logic                     slot_started;
    } slot_report_t;

    logic signed [TEMP_W-1:0] last_temp;
    logic signed [TEMP_W-1:0] low_mark;
    logic signed [TEMP_W-1:0] high_mark;
    logic [SLOT_W-1:0]        cur_slot;
    logic signed [TEMP_W-1:0] mean_mem [NUM_SLOTS];
    logic [CNT_W-1:0]         count_mem [NUM_SLOTS];

    slot_report_t owed_reports [$];

    function automatic void clear_stats();
        for (int i = 0; i < NUM_SLOTS; i++) begin
            mean_mem[i]  = '0;
            count_mem[i] = '0;
        end
        low_mark  = MIN_RESET;
        high_mark = MAX_RESET;
    endfunction

    // Applies one request to the tracked statistics and returns the report it yields.
    function automatic slot_report_t advance_slot_stats(
        input logic [1:0]               req,
        input logic signed [TEMP_W-1:0] x,
        input logic [4:0]               hr,
        input logic [5:0]               mn
    );
        slot_report_t rep;
        int           idx;
        longint       acc;
        longint       divisor;
        longint       quot;

        rep = '0;
        case (req)
            REQ_SAMPLE: begin
                last_temp = x;
                if (x < low_mark)
                    low_mark = x;
                if (x > high_mark)
                    high_mark = x;
                idx = (int'(hr) * MIN_PER_HOUR + int'(mn)) / MINUTES_PER_SLOT;
                if (idx >= NUM_SLOTS)
                    idx = NUM_SLOTS - 1;
                if (idx != int'(cur_slot)) begin
                    cur_slot          = idx[SLOT_W-1:0];
                    mean_mem[idx]     = x;
                    count_mem[idx]    = 1;
                    rep.slot_started  = 1'b1;
                end else begin
                    // Running mean; once the count is pinned the divisor stays at 65536.
                    acc     = longint'(mean_mem[idx]) * longint'(count_mem[idx]) + longint'(x);
                    divisor = longint'(count_mem[idx]) + 1;
                    quot    = acc / divisor;
                    mean_mem[idx] = quot[TEMP_W-1:0];
                    if (count_mem[idx] != CNT_MAX)
                        count_mem[idx] = count_mem[idx] + 1'b1;
                end
            end
            REQ_RESET_MM: begin
                low_mark  = MIN_RESET;
                high_mark = MAX_RESET;
            end
            REQ_CLEAR: begin
                clear_stats();
            end
            default: begin
            end
        endcase

        rep.now_temp    = last_temp;
        rep.min_seen    = low_mark;
        rep.max_seen    = high_mark;
        rep.slot_number = cur_slot;
        if (int'(cur_slot) < NUM_SLOTS) begin
            rep.slot_mean    = mean_mem[cur_slot];
            rep.slot_samples = count_mem[cur_slot];
        end
        return rep;
    endfunction

    always @(posedge clk or negedge rst_n) begin : watch
        slot_report_t seen;
        slot_report_t want;

        if (!rst_n) begin
            last_temp = '0;
            cur_slot  = NO_SLOT;
            clear_stats();
            owed_reports.delete();
            fail_count = 0;
            pending    = 0;
            checked    = 0;
        end else begin
            // The result side is handled first, so that a request taken at this
            // edge can never stand in for a result that had nothing waiting.
            if (out_valid && !out_stall) begin
                seen = {now_temp, min_seen, max_seen, slot_number,
                        slot_mean, slot_samples, slot_started};
                if (owed_reports.size() == 0) begin
                    fail_count++;
                    if (fail_count <= SHOW_LIMIT)
                        $display("%0t: result transfer with no request outstanding", $time);
                end else begin
                    want = owed_reports.pop_front();
                    checked++;
                    if (seen !== want) begin
                        fail_count++;
                        if (fail_count <= SHOW_LIMIT) begin
                            $display("%0t: mismatch on result %0d", $time, checked);
                            $display("  expected now=%0d min=%0d max=%0d slot=%0d mean=%0d n=%0d new=%0b",
                                     $signed(want.now_temp), $signed(want.min_seen),
                                     $signed(want.max_seen), want.slot_number,
                                     $signed(want.slot_mean), want.slot_samples,
                                     want.slot_started);
                            $display("  actual   now=%0d min=%0d max=%0d slot=%0d mean=%0d n=%0d new=%0b",
                                     $signed(seen.now_temp), $signed(seen.min_seen),
                                     $signed(seen.max_seen), seen.slot_number,
                                     $signed(seen.slot_mean), seen.slot_samples,
                                     seen.slot_started);
                        end
                    end
                end
            end
            if (in_valid && !in_stall)
                owed_reports.push_back(advance_slot_stats(req_type, temperature, hour, minute));
            pending = owed_reports.size();
        end
    end

endmodule

// ===== verif/tb_top.sv =====
// Top of the testbench: clock, reset, request stimulus, result stalls and the verdict.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tsamm_pkg::*;

    localparam int NUM_SLOTS        = DEF_NUM_SLOTS;
    localparam int MINUTES_PER_SLOT = DEF_MIN_PER_SLOT;

    // The request code that the block accepts but does nothing with.
    localparam logic [1:0] REQ_UNUSED = 2'd3;

    localparam int CLK_HALF     = 10;
    localparam int RESET_CYCLES = 11;

    // Random part sizing: the mode is redrawn once at least MODE_SPAN transfers
    // have passed, and picks made in the last QUIET_ITEMS transfers run with neither side idling.
    localparam int RAND_ITEMS  = 1600;
    localparam int MODE_SPAN   = 100;
    localparam int QUIET_ITEMS = 200;

    // The settle time is longer than a sample in the active slot takes, so
    // it is plenty for anything stray to show up after the last result.
    localparam int SETTLE_CYCLES = 64;
    localparam int DRAIN_LIMIT   = 5000;

    // The watchdog allows several times the slowest correct run, in which every
    // transfer is a running-mean sample behind a long gap and a long stall.
    localparam int TIMEOUT_NS = 20_000_000;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     in_valid;
    logic                     in_stall;
    logic [1:0]               req_type;
    logic signed [TEMP_W-1:0] temperature;
    logic [4:0]               hour;
    logic [5:0]               minute;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic signed [TEMP_W-1:0] now_temp;
    logic signed [TEMP_W-1:0] min_seen;
    logic signed [TEMP_W-1:0] max_seen;
    logic [SLOT_W-1:0]        slot_number;
    logic signed [TEMP_W-1:0] slot_mean;
    logic [CNT_W-1:0]         slot_samples;
    logic                     slot_started;

    int fail_count;
    int pending;
    int checked;

    // Idling controls. gap_on is only touched by the stimulus process; stall_on
    // is read by the stall generator, so it is updated with nonblocking writes.
    bit gap_on   = 1'b1;
    bit stall_on = 1'b1;
    int stall_left = 0;

    int sent_by_req [4];
    int sent_total;

    always #(CLK_HALF) clk = ~clk;

    time_slot_average_min_max #(
        .NUM_SLOTS        (NUM_SLOTS),
        .MINUTES_PER_SLOT (MINUTES_PER_SLOT)
    ) u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .temperature  (temperature),
        .hour         (hour),
        .minute       (minute),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .now_temp     (now_temp),
        .min_seen     (min_seen),
        .max_seen     (max_seen),
        .slot_number  (slot_number),
        .slot_mean    (slot_mean),
        .slot_samples (slot_samples),
        .slot_started (slot_started)
    );

    tsamm_scoreboard #(
        .NUM_SLOTS        (NUM_SLOTS),
        .MINUTES_PER_SLOT (MINUTES_PER_SLOT)
    ) u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .req_type     (req_type),
        .temperature  (temperature),
        .hour         (hour),
        .minute       (minute),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .now_temp     (now_temp),
        .min_seen     (min_seen),
        .max_seen     (max_seen),
        .slot_number  (slot_number),
        .slot_mean    (slot_mean),
        .slot_samples (slot_samples),
        .slot_started (slot_started),
        .fail_count   (fail_count),
        .pending      (pending),
        .checked      (checked)
    );

    // Result-side stalls. When enabled, a stall burst starts at random,
    // independent of out_valid, so stalls land on every phase of the
    // block's work, including while the output register holds a result.
    always @(posedge clk) begin
        if (!stall_on) begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            out_stall  <= 1'b1;
            stall_left <= stall_left - 1;
        end else if ($urandom_range(0, 3) == 0) begin
            out_stall  <= 1'b1;
            stall_left <= $urandom_range(0, 11);
        end else begin
            out_stall <= 1'b0;
        end
    end

    // Presents one request and holds it until the transfer happens. An optional
    // gap with valid low comes first. The valid line is only lowered when a gap
    // follows, so it is never dropped and raised in the same step. The loop reads
    // in_stall right after the edge, which is the value the block had at that
    // edge, so the transfer is seen exactly where it happens.
    task automatic send_req(
        input logic [1:0]               req,
        input logic signed [TEMP_W-1:0] x,
        input logic [4:0]               hr,
        input logic [5:0]               mn
    );
        int gap;

        if (gap_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 12);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        temperature <= x;
        hour        <= hr;
        minute      <= mn;
        do
            @(posedge clk);
        while (in_stall);
        sent_by_req[req]++;
        sent_total++;
    endtask

    // A sample at a random time of day inside the given slot.
    task automatic send_in_slot(input int slot, input logic signed [TEMP_W-1:0] x);
        int day_min;

        day_min = slot * MINUTES_PER_SLOT + int'($urandom_range(0, MINUTES_PER_SLOT - 1));
        send_req(REQ_SAMPLE, x, 5'(day_min / MIN_PER_HOUR), 6'(day_min % MIN_PER_HOUR));
    endtask

    // Temperature for one sample of a run: fully random, spread around a base
    // value so the running mean stays meaningful, or one of the two extremes.
    function automatic logic signed [TEMP_W-1:0] run_temp(input int style, input int base);
        int t;

        case (style)
            0: t = int'($signed(16'($urandom())));
            1: begin
                t = base + int'($urandom_range(0, 1024)) - 512;
                if (t > 32767)
                    t = 32767;
                if (t < -32768)
                    t = -32768;
            end
            default: t = ($urandom_range(0, 1) == 0) ? -32768 : 32767;
        endcase
        return t[TEMP_W-1:0];
    endfunction

    initial begin : stimulus
        int                       pick;
        int                       run_len;
        int                       style;
        int                       base;
        int                       slot;
        int                       rand_sent;
        int                       next_mode_at;
        int                       drain;
        bit                       fixed_time;
        logic [4:0]               hr;
        logic [5:0]               mn;
        logic signed [TEMP_W-1:0] x;

        // Every input is known from time zero, while reset is held low at the start.
        rst_n       <= 1'b0;
        in_valid    <= 1'b0;
        req_type    <= REQ_SAMPLE;
        temperature <= '0;
        hour        <= '0;
        minute      <= '0;
        sent_total   = 0;
        foreach (sent_by_req[i])
            sent_by_req[i] = 0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---------------- Directed part ----------------
        // Requests before any sample: no slot is open yet, so the slot mean and
        // count must read zero and the slot number must read "none".
        send_req(REQ_RESET_MM, 16'sh7FFF, 5'd31, 6'd63);
        send_req(REQ_UNUSED,   16'sh8000, 5'd0,  6'd0);
        send_req(REQ_CLEAR,    16'sh7FFF, 5'd31, 6'd63);

        // Slot 0 with both temperature extremes: the mean of -32768 and 32767
        // truncates toward zero to 0, then a third sample pulls it negative.
        send_req(REQ_SAMPLE, 16'sh8000, 5'd0, 6'd0);
        send_req(REQ_SAMPLE, 16'sh7FFF, 5'd0, 6'd14);
        send_req(REQ_SAMPLE, 16'sh8000, 5'd0, 6'd7);

        // Last slot of the day, then times past the end of the day, which must
        // saturate into the last slot and keep averaging there.
        send_req(REQ_SAMPLE, 16'sd1, 5'd23, 6'd59);
        send_req(REQ_SAMPLE, 16'sd0, 5'd31, 6'd63);
        send_req(REQ_SAMPLE, 16'sd3, 5'd24, 6'd0);

        // A minute above 59 still goes into the formula (0:63 is slot 4).
        send_req(REQ_SAMPLE, 16'sd100, 5'd0, 6'd63);
        send_req(REQ_RESET_MM, 16'sd0, 5'd0, 6'd0);
        send_req(REQ_UNUSED,   16'sd0, 5'd0, 6'd0);
        send_req(REQ_SAMPLE, 16'sd12801, 5'd0, 6'd60);

        // A clear keeps the active slot: the next sample in that slot averages
        // against an empty count, so it is not flagged as a new slot.
        send_req(REQ_CLEAR, 16'sd0, 5'd0, 6'd0);
        send_req(REQ_SAMPLE, -16'sd5, 5'd1, 6'd0);
        send_req(REQ_SAMPLE, -16'sd6, 5'd1, 6'd5);

        // Alternating bit patterns on the fields of most of these requests.
        send_req(REQ_SAMPLE, 16'sd256, 5'd12, 6'd34);
        send_req(REQ_SAMPLE, 16'sh5555, 5'h15, 6'h2A);
        send_req(REQ_SAMPLE, 16'shAAAA, 5'h0A, 6'h15);
        send_req(REQ_SAMPLE, 16'shAAAA, 5'h0A, 6'h16);
        send_req(REQ_CLEAR, 16'sh5555, 5'h15, 6'h2A);

        // ---------------- Random part ----------------
        // Mostly runs of samples within one slot so the running mean gets deep,
        // mixed with slot changes, out-of-range times, extreme resets, clears
        // and the unused code.
        rand_sent    = 0;
        next_mode_at = 0;
        while (rand_sent < RAND_ITEMS) begin
            if (rand_sent >= RAND_ITEMS - QUIET_ITEMS) begin
                gap_on    = 1'b0;
                stall_on <= 1'b0;
            end else if (rand_sent >= next_mode_at) begin
                gap_on        = ($urandom_range(0, 3) != 0);
                stall_on     <= ($urandom_range(0, 3) != 0);
                next_mode_at  = rand_sent + MODE_SPAN;
            end

            pick = $urandom_range(0, 99);
            if (pick < 6) begin
                send_req(REQ_RESET_MM, 16'($urandom()), 5'($urandom()), 6'($urandom()));
                rand_sent++;
            end else if (pick < 10) begin
                send_req(REQ_CLEAR, 16'($urandom()), 5'($urandom()), 6'($urandom()));
                rand_sent++;
            end else if (pick < 13) begin
                send_req(REQ_UNUSED, 16'($urandom()), 5'($urandom()), 6'($urandom()));
                rand_sent++;
            end else if (pick < 20) begin
                // A lone sample with every field fully random.
                send_req(REQ_SAMPLE, 16'($urandom()), 5'($urandom()), 6'($urandom()));
                rand_sent++;
            end else begin
                run_len    = ($urandom_range(0, 19) == 0) ? $urandom_range(41, 150)
                                                          : $urandom_range(1, 40);
                style      = $urandom_range(0, 5);
                style      = (style < 2) ? 0 : ((style < 5) ? 1 : 2);
                base       = int'($signed(16'($urandom())));
                slot       = $urandom_range(0, NUM_SLOTS - 1);
                fixed_time = ($urandom_range(0, 6) == 0);
                hr         = 5'($urandom());
                mn         = 6'($urandom());
                for (int k = 0; k < run_len; k++) begin
                    x = run_temp(style, base);
                    if (fixed_time)
                        send_req(REQ_SAMPLE, x, hr, mn);
                    else
                        send_in_slot(slot, x);
                    rand_sent++;
                end
            end
        end

        // ---------------- Drain and verdict ----------------
        in_valid <= 1'b0;
        stall_on <= 1'b0;
        // One more edge so the checker has recorded the last transfer before
        // its outstanding count is read.
        @(posedge clk);
        drain = 0;
        while (pending != 0 && drain < DRAIN_LIMIT) begin
            @(posedge clk);
            drain++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (pending != 0)
            $display("%0d results never arrived.", pending);
        $display("Sent %0d requests: %0d samples, %0d min/max resets, %0d clears, %0d unused codes.",
                 sent_total, sent_by_req[REQ_SAMPLE], sent_by_req[REQ_RESET_MM],
                 sent_by_req[REQ_CLEAR], sent_by_req[REQ_UNUSED]);
        $display("Compared %0d results against the prediction, %0d failures.",
                 checked, fail_count);
        if (fail_count == 0 && pending == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #(TIMEOUT_NS);
        $display("Timeout: the run did not reach its end.");
        $display("*** FAILED ***");
        $finish;
    end

endmodule
